[rtl/prd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prd_pkg: shared types and codes of the parity routed deque
// Payload structs of both channels, status and request codes, and the
// command and status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package prd_pkg;

   localparam logic REQ_PUSH   = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int XFER_WIDTH  = 32;
   localparam int COUNT_WIDTH = 9;

   typedef struct packed {
      logic                         req_type;
      logic signed [XFER_WIDTH-1:0] data_in;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic signed [XFER_WIDTH-1:0] data_out;
      logic [COUNT_WIDTH-1:0]       count;
      logic                         is_empty;
   } rsp_payload_type;

   typedef struct packed {
      logic take;
      logic load_read;
   } dp_cmd_type;

   typedef struct packed {
      logic needs_read;
   } dp_sts_type;

endpackage
`default_nettype wire

[rtl/prd_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prd_if: request and response channels
// Valid/ready channels carrying the request and response payload structs.
// ----------------------------------------------------------------------------
interface prd_req_if;
   logic                     valid;
   logic                     ready;
   prd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface prd_rsp_if;
   logic                     valid;
   logic                     ready;
   prd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/parity_routed_deque_unit.sv]
`default_nettype none
// Push, and a remove that finds the store empty: response valid in the cycle after transfer.
// Successful remove: the registered RAM read, then the S_READ state, load the response.
// Throughput: one push or empty remove per cycle while responses are taken; no new request during S_READ.
// A new request is taken in the cycle the pending response transfers.
// Reset clears the pointers, the fill count and the handshake state;
// RAM contents stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// parity_routed_deque_unit: deque whose end is chosen by word parity
// Even words enter and leave at the front, odd ones at the back; every
// request gives one response with status, removed word and fill count.
// ----------------------------------------------------------------------------
module parity_routed_deque_unit #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   prd_req_if.sink    req_chan,
   prd_rsp_if.source  rsp_chan
);
   import prd_pkg::*;

   dp_cmd_type      cmd;
   dp_sts_type      sts;
   rsp_payload_type rsp_payload;

   prd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   prd_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_chan.payload),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_payload)
   );

   assign rsp_chan.payload = rsp_payload;

endmodule
`default_nettype wire

[rtl/prd_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prd_ram: generic single write port, single read port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module prd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[rtl/prd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prd_ctrl: deque controller
// Runs the request/response handshakes and sequences the S_READ state that a
// successful remove needs for the registered RAM read.
// ----------------------------------------------------------------------------
module prd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire prd_pkg::dp_sts_type sts,
   output prd_pkg::dp_cmd_type      cmd
);
   import prd_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic take;

   // the response register is free, or drains in this same cycle
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      cmd.take      = take;
      cmd.load_read = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (take && sts.needs_read) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.load_read = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if ((take && !sts.needs_read) || cmd.load_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[rtl/prd_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prd_dp: deque datapath
// Circular buffer in RAM with front and back pointers and a fill count;
// builds the response payload register.
// ----------------------------------------------------------------------------
module prd_dp #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire prd_pkg::req_payload_type req,
   input  wire prd_pkg::dp_cmd_type      cmd,
   output prd_pkg::dp_sts_type           sts,
   output prd_pkg::rsp_payload_type      rsp
);
   import prd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0] front_ff, front_in;
   logic [AW-1:0] back_ff, back_in;
   logic [CW-1:0] count_ff, count_in;

   logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;
   logic          is_push, odd, empty, full;
   logic [1:0]    status_code;

   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
   logic [XFER_WIDTH-1:0] rd_ext;
   logic [COUNT_WIDTH-1:0] count_out;

   logic [1:0]                   status_ff;
   logic signed [XFER_WIDTH-1:0] data_out_ff;
   logic [COUNT_WIDTH-1:0]       count_out_ff;
   logic                         is_empty_ff;

   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign back_inc  = (back_ff == AW'(DEPTH - 1)) ? '0 : back_ff + AW'(1);
   assign back_dec  = (back_ff == '0) ? AW'(DEPTH - 1) : back_ff - AW'(1);

   assign is_push = (req.req_type == REQ_PUSH);
   assign odd     = req.data_in[0];
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(DEPTH));

   assign sts.needs_read = !is_push && !empty;

   always_comb begin
      front_in    = front_ff;
      back_in     = back_ff;
      count_in    = count_ff;
      ram_waddr   = back_ff;
      ram_raddr   = front_ff;
      status_code = ST_DONE;
      if (is_push) begin
         if (full) begin
            status_code = ST_FULL;
         end else if (!odd) begin
            front_in  = front_dec;
            ram_waddr = front_dec;
            count_in  = count_ff + CW'(1);
         end else begin
            ram_waddr = back_ff;
            back_in   = back_inc;
            count_in  = count_ff + CW'(1);
         end
      end else begin
         if (empty) begin
            status_code = ST_EMPTY;
         end else if (!odd) begin
            ram_raddr = front_ff;
            front_in  = front_inc;
            count_in  = count_ff - CW'(1);
         end else begin
            ram_raddr = back_dec;
            back_in   = back_dec;
            count_in  = count_ff - CW'(1);
         end
      end
   end

   assign ram_we = cmd.take && is_push && !full;
   assign ram_re = cmd.take && sts.needs_read;

   generate
      if (DATA_WIDTH > XFER_WIDTH) begin : g_wide
         assign ram_wdata = {{(DATA_WIDTH - XFER_WIDTH){1'b0}}, req.data_in};
         assign rd_ext    = ram_rdata[XFER_WIDTH-1:0];
      end else if (DATA_WIDTH == XFER_WIDTH) begin : g_equal
         assign ram_wdata = req.data_in;
         assign rd_ext    = ram_rdata;
      end else begin : g_narrow
         assign ram_wdata = req.data_in[DATA_WIDTH-1:0];
         assign rd_ext    = {{(XFER_WIDTH - DATA_WIDTH){ram_rdata[DATA_WIDTH-1]}},
                             ram_rdata};
      end
   endgenerate

   generate
      if (CW >= COUNT_WIDTH) begin : g_cnt_trunc
         assign count_out = count_in[COUNT_WIDTH-1:0];
      end else begin : g_cnt_ext
         assign count_out = {{(COUNT_WIDTH - CW){1'b0}}, count_in};
      end
   endgenerate

   prd_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.take) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   // data_out stays zero unless a successful remove fills it from the RAM read
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         status_ff    <= status_code;
         data_out_ff  <= '0;
         count_out_ff <= count_out;
         is_empty_ff  <= (count_in == '0);
      end else if (cmd.load_read) begin
         data_out_ff <= rd_ext;
      end
   end

   assign rsp.status   = status_ff;
   assign rsp.data_out = data_out_ff;
   assign rsp.count    = count_out_ff;
   assign rsp.is_empty = is_empty_ff;

endmodule
`default_nettype wire
